>>> rtl/core/upb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upb_pkg
// Shared types and constants of the ultrasonic proximity blinker: register
// indexes, field widths, reset values and the transfer payloads.
// ----------------------------------------------------------------------------
package upb_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TRIGGER_PERIOD = 3'd0,
		CFG_TRIGGER_WIDTH  = 3'd1,
		CFG_NEAR_LIMIT     = 3'd2,
		CFG_FAR_LIMIT      = 3'd3,
		CFG_FASTEST_WAIT   = 3'd4
	} cfg_index_t;

	// register and field widths
	localparam int PERIOD_W = 20;
	localparam int PULSE_W  = 8;
	localparam int LIMIT_W  = 16;
	localparam int FAST_W   = 16;
	localparam int DIST_W   = 17;

	// register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 20'd20000;
	localparam logic [PULSE_W-1:0]  WIDTH_RESET   = 8'd5;
	localparam logic [LIMIT_W-1:0]  NEAR_RESET    = 16'd250;
	localparam logic [LIMIT_W-1:0]  FAR_RESET     = 16'd1250;
	localparam logic [FAST_W-1:0]   FASTEST_RESET = 16'd5000;

	// echo ticks to millimetres: (ticks * 439) >> 8
	localparam int                   CONV_BITS   = 9;
	localparam int                   CONV_SHIFT  = 8;
	localparam logic [CONV_BITS-1:0] CONV_FACTOR = 9'd439;
	localparam logic [DIST_W-1:0]    DIST_MAX    = 17'h1FFFF;

	// serial multiply and divide
	localparam int PROD_W    = FAST_W + LIMIT_W;
	localparam int MUL_STEPS = FAST_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int STEP_W    = 5;

	// transfer payloads
	typedef struct packed {
		logic echo_level;
	} in_item_t;

	typedef struct packed {
		logic              trigger_out;
		logic              led_out;
		logic [DIST_W-1:0] distance_mm;
		logic              distance_new;
	} out_item_t;

endpackage
`default_nettype wire

>>> rtl/core/upb_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upb_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface upb_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

>>> rtl/core/ultrasonic_proximity_blinker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_proximity_blinker
// Parking-sensor indicator: trigger pulse generator, echo timer with
// millimetre conversion, and a proximity LED that blinks faster when closer.
// ----------------------------------------------------------------------------
// One input transfer is one 10 us tick carrying the sampled echo level; each
// tick yields exactly one result transfer (trigger level, LED level, latest
// distance and a new-distance flag). Each tick runs the 16-step bit-serial
// multiply of fastest wait by the band width (the echo conversion shares
// those steps); when the LED toggles inside the blink band and a new wait
// must be worked out, the 32-step restoring divider for the wait follows.
// The next tick is taken once the result is loaded into the output
// register, and that load waits while an earlier result is still untaken.
module ultrasonic_proximity_blinker #(
	parameter int ECHO_COUNT_WIDTH = 16,
	parameter int WAIT_COUNT_WIDTH = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [upb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [upb_pkg::CFG_DATA_W-1:0]   cfg_data,
	upb_stream_if.sink                            echo,
	upb_stream_if.source                          result
);

	localparam int EW     = ECHO_COUNT_WIDTH;
	localparam int WW     = WAIT_COUNT_WIDTH;
	localparam int ACC_W  = EW + upb_pkg::CONV_BITS;
	localparam int MM_W   = ACC_W - upb_pkg::CONV_SHIFT;
	localparam int CMP_W  = (MM_W > upb_pkg::DIST_W) ? MM_W : upb_pkg::DIST_W;
	localparam int PW     = upb_pkg::PROD_W;
	localparam int DW     = upb_pkg::DIST_W;
	localparam int LW     = upb_pkg::LIMIT_W;
	localparam int SW     = upb_pkg::STEP_W;

	localparam logic [EW-1:0] ECHO_MAX = '1;
	localparam logic [WW-1:0] WAIT_MAX = '1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CALC   = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_WLOAD  = 6'b010000,
		ST_WB     = 6'b100000
	} state_t;

	state_t state_q;
	logic [SW-1:0] step_q;

	// configuration registers
	logic [upb_pkg::PERIOD_W-1:0] period_cfg_q;
	logic [upb_pkg::PULSE_W-1:0]  width_cfg_q;
	logic [LW-1:0]                near_cfg_q;
	logic [LW-1:0]                far_cfg_q;
	logic [upb_pkg::FAST_W-1:0]   fastest_cfg_q;

	// tick state
	logic [upb_pkg::PERIOD_W-1:0] period_q;
	logic [upb_pkg::PULSE_W-1:0]  pulse_q;
	logic [EW-1:0]                echo_cnt_q;
	logic                         echo_prev_q;
	logic [DW-1:0]                distance_q;
	logic                         led_q;
	logic [WW-1:0]                wait_q;
	logic                         trig_q;
	logic                         new_q;
	logic                         out_valid_q;

	// datapath registers
	logic [EW-1:0]                    cap_q;
	logic [ACC_W-1:0]                 conv_acc_q;
	logic [upb_pkg::CONV_BITS-1:0]    fac_sr_q;
	logic [PW-1:0]                    prod_q;
	logic [upb_pkg::FAST_W-1:0]       mul_sr_q;
	logic [PW-1:0]                    div_q;
	logic [LW-1:0]                    rem_q;
	logic [LW-1:0]                    den_q;
	upb_pkg::out_item_t               out_q;

	// handshakes
	logic accept;
	logic wb_load;

	assign echo.ready     = (state_q == ST_IDLE);
	assign accept         = echo.valid && echo.ready;
	assign wb_load        = (state_q == ST_WB) && (!out_valid_q || result.ready);
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// trigger generator for this tick
	logic [upb_pkg::PULSE_W-1:0]  pulse_load;
	logic                         trig_now;
	logic [upb_pkg::PERIOD_W:0]   period_inc;
	logic                         period_wrap;

	assign pulse_load  = (period_q == '0) ? width_cfg_q : pulse_q;
	assign trig_now    = (pulse_load != '0);
	assign period_inc  = {1'b0, period_q} + (upb_pkg::PERIOD_W+1)'(1);
	assign period_wrap = (period_inc >= {1'b0, period_cfg_q});

	// converted distance with saturation
	logic [MM_W-1:0]  mm;
	logic [CMP_W-1:0] mm_ext;
	logic [DW-1:0]    dist_conv;

	assign mm        = conv_acc_q[ACC_W-1:upb_pkg::CONV_SHIFT];
	assign mm_ext    = CMP_W'(mm);
	assign dist_conv = (mm_ext > CMP_W'(upb_pkg::DIST_MAX)) ? upb_pkg::DIST_MAX
		: DW'(mm_ext);

	// blink band width and wait denominator
	logic [LW-1:0] band;
	logic [LW-1:0] den_next;

	assign band     = far_cfg_q - near_cfg_q;
	assign den_next = far_cfg_q - distance_q[LW-1:0];

	// one restoring divide step
	logic [LW:0]   trial;
	logic          fits;
	logic [LW:0]   trial_sub;

	assign trial     = {rem_q, div_q[PW-1]};
	assign fits      = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	// quotient saturation and wait load value
	logic [WW-1:0] q_sat;
	logic [WW-1:0] wait_load;

	assign q_sat     = (div_q > PW'(WAIT_MAX)) ? WAIT_MAX : WW'(div_q);
	assign wait_load = (q_sat == '0) ? '0 : q_sat - WW'(1);

	// control, configuration and tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			period_cfg_q  <= upb_pkg::PERIOD_RESET;
			width_cfg_q   <= upb_pkg::WIDTH_RESET;
			near_cfg_q    <= upb_pkg::NEAR_RESET;
			far_cfg_q     <= upb_pkg::FAR_RESET;
			fastest_cfg_q <= upb_pkg::FASTEST_RESET;
			period_q      <= '0;
			pulse_q       <= '0;
			echo_cnt_q    <= '0;
			echo_prev_q   <= 1'b0;
			distance_q    <= '0;
			led_q         <= 1'b0;
			wait_q        <= '0;
			trig_q        <= 1'b0;
			new_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					upb_pkg::CFG_TRIGGER_PERIOD: period_cfg_q  <= cfg_data[upb_pkg::PERIOD_W-1:0];
					upb_pkg::CFG_TRIGGER_WIDTH:  width_cfg_q   <= cfg_data[upb_pkg::PULSE_W-1:0];
					upb_pkg::CFG_NEAR_LIMIT:     near_cfg_q    <= cfg_data[LW-1:0];
					upb_pkg::CFG_FAR_LIMIT:      far_cfg_q     <= cfg_data[LW-1:0];
					upb_pkg::CFG_FASTEST_WAIT:   fastest_cfg_q <= cfg_data[upb_pkg::FAST_W-1:0];
					default: ;
				endcase
			end

			// result register loads on write-back, drains on transfer
			if (wb_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// trigger line
						pulse_q  <= trig_now ? pulse_load - upb_pkg::PULSE_W'(1) : '0;
						period_q <= period_wrap ? '0 : period_inc[upb_pkg::PERIOD_W-1:0];
						trig_q   <= trig_now;
						// echo timing
						if (echo.payload.echo_level) begin
							if (!echo_prev_q) begin
								echo_cnt_q <= EW'(1);
							end else if (echo_cnt_q != ECHO_MAX) begin
								echo_cnt_q <= echo_cnt_q + EW'(1);
							end
							new_q <= 1'b0;
						end else if (echo_prev_q) begin
							echo_cnt_q <= '0;
							new_q      <= 1'b1;
						end else begin
							new_q <= 1'b0;
						end
						echo_prev_q <= echo.payload.echo_level;
						step_q      <= '0;
						state_q     <= ST_CALC;
					end
				end
				ST_CALC: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(upb_pkg::MUL_STEPS - 1)) begin
						if (new_q) begin
							distance_q <= dist_conv;
						end
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// indicator decision on the updated distance
					if (wait_q != '0) begin
						wait_q  <= wait_q - WW'(1);
						state_q <= ST_WB;
					end else if (distance_q > {1'b0, far_cfg_q}) begin
						led_q   <= 1'b0;
						state_q <= ST_WB;
					end else if (distance_q > {1'b0, near_cfg_q}) begin
						led_q <= ~led_q;
						if (distance_q >= {1'b0, far_cfg_q}) begin
							wait_q  <= WAIT_MAX - WW'(1);
							state_q <= ST_WB;
						end else begin
							step_q  <= '0;
							state_q <= ST_DIV;
						end
					end else begin
						led_q   <= 1'b1;
						state_q <= ST_WB;
					end
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(upb_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_WLOAD;
					end
				end
				ST_WLOAD: begin
					wait_q  <= wait_load;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// serial datapath and result register
	always_ff @(posedge clk) begin
		// capture the finished echo count and arm the serial units
		if (accept) begin
			if (!echo.payload.echo_level && echo_prev_q) begin
				cap_q <= echo_cnt_q;
			end
			conv_acc_q <= '0;
			fac_sr_q   <= upb_pkg::CONV_FACTOR;
			prod_q     <= '0;
			mul_sr_q   <= fastest_cfg_q;
		end

		// one bit of the conversion factor and of fastest wait per cycle
		if (state_q == ST_CALC) begin
			if (step_q < SW'(upb_pkg::CONV_BITS)) begin
				conv_acc_q <= {conv_acc_q[ACC_W-2:0], 1'b0}
					+ (fac_sr_q[upb_pkg::CONV_BITS-1] ? ACC_W'(cap_q) : '0);
				fac_sr_q   <= {fac_sr_q[upb_pkg::CONV_BITS-2:0], 1'b0};
			end
			prod_q   <= {prod_q[PW-2:0], 1'b0}
				+ (mul_sr_q[upb_pkg::FAST_W-1] ? PW'(band) : '0);
			mul_sr_q <= {mul_sr_q[upb_pkg::FAST_W-2:0], 1'b0};
		end

		// divider operands
		if (state_q == ST_DECIDE) begin
			div_q <= prod_q;
			rem_q <= '0;
			den_q <= den_next;
		end

		// one quotient bit per cycle
		if (state_q == ST_DIV) begin
			rem_q <= fits ? trial_sub[LW-1:0] : trial[LW-1:0];
			div_q <= {div_q[PW-2:0], fits};
		end

		// result for this tick
		if (wb_load) begin
			out_q.trigger_out  <= trig_q;
			out_q.led_out      <= led_q;
			out_q.distance_mm  <= distance_q;
			out_q.distance_new <= new_q;
		end
	end

endmodule
`default_nettype wire

>>> sim/ultrasonic_proximity_blinker_tb.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_proximity_blinker_tb
// Self-checking bench for the proximity blinker. Echo ticks go in through a
// valid/ready source with random gaps, results are drained with random stalls,
// and every result is compared with a cycle-free model of the trigger
// generator, echo timer and blink logic kept inside the bench.
// ----------------------------------------------------------------------------
module ultrasonic_proximity_blinker_tb;

	localparam int                ECHO_W      = 16;
	localparam int                WAIT_W      = 24;
	localparam logic [WAIT_W-1:0] WAIT_MAX    = {WAIT_W{1'b1}};
	localparam int                STALL_LIMIT = 2000;
	localparam int                TAIL_CYCLES = 120;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [upb_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [upb_pkg::CFG_DATA_W-1:0]  cfg_data;

	upb_stream_if #(.payload_t(upb_pkg::in_item_t))  echo_ch ();
	upb_stream_if #(.payload_t(upb_pkg::out_item_t)) result_ch ();

	ultrasonic_proximity_blinker #(
		.ECHO_COUNT_WIDTH(ECHO_W),
		.WAIT_COUNT_WIDTH(WAIT_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.echo     (echo_ch),
		.result   (result_ch)
	);

	// settings as the block holds them
	logic [upb_pkg::PERIOD_W-1:0] period_reg;
	logic [upb_pkg::PULSE_W-1:0]  width_reg;
	logic [upb_pkg::LIMIT_W-1:0]  near_reg;
	logic [upb_pkg::LIMIT_W-1:0]  far_reg;
	logic [upb_pkg::FAST_W-1:0]   fastest_reg;

	// sensor state as the block holds it
	logic [upb_pkg::PERIOD_W-1:0] period_cnt;
	logic [upb_pkg::PULSE_W-1:0]  pulse_cnt;
	logic [ECHO_W-1:0]            echo_cnt;
	logic                         echo_prev;
	logic [upb_pkg::DIST_W-1:0]   dist_reg;
	logic                         led_reg;
	logic [WAIT_W-1:0]            wait_cnt;

	upb_pkg::out_item_t pending_readings[$];
	int                 mismatch_count = 0;
	int                 quiet_cycles   = 0;
	bit                 tx_steady      = 1'b0;
	bit                 rx_steady      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// echo ticks to millimetres: 439/256 mm per tick of round trip
	function automatic logic [upb_pkg::DIST_W-1:0] ticks_to_mm(
			input logic [ECHO_W-1:0] ticks);
		logic [63:0] mm;
		mm = (64'(ticks) * 64'd439) >> 8;
		if (mm > 64'h1FFFF)
			mm = 64'h1FFFF;
		return mm[upb_pkg::DIST_W-1:0];
	endfunction

	// hold time between toggles, closer means shorter
	function automatic logic [WAIT_W-1:0] blink_ticks(
			input logic [upb_pkg::DIST_W-1:0] d);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		if (d >= upb_pkg::DIST_W'(far_reg))
			return WAIT_MAX;
		den = 64'(far_reg) - 64'(d);
		num = 64'(fastest_reg) * (64'(far_reg) - 64'(near_reg));
		q = num / den;
		if (q > 64'(WAIT_MAX))
			q = 64'(WAIT_MAX);
		return q[WAIT_W-1:0];
	endfunction

	// one 10 us tick of trigger, echo timer and indicator
	task automatic advance_sensor(input logic lvl, output upb_pkg::out_item_t res);
		logic                       trig;
		logic                       fresh;
		logic [WAIT_W-1:0]          w;
		logic [upb_pkg::PERIOD_W:0] next_p;
		fresh = 1'b0;

		// trigger generator
		if (period_cnt == '0)
			pulse_cnt = width_reg;
		trig = (pulse_cnt != '0);
		if (pulse_cnt != '0)
			pulse_cnt = pulse_cnt - upb_pkg::PULSE_W'(1);
		next_p = {1'b0, period_cnt} + (upb_pkg::PERIOD_W+1)'(1);
		if (next_p >= {1'b0, period_reg})
			period_cnt = '0;
		else
			period_cnt = next_p[upb_pkg::PERIOD_W-1:0];

		// echo timer, distance latched on the falling edge
		if (lvl) begin
			if (!echo_prev)
				echo_cnt = ECHO_W'(1);
			else if (echo_cnt != '1)
				echo_cnt = echo_cnt + ECHO_W'(1);
		end else if (echo_prev) begin
			dist_reg = ticks_to_mm(echo_cnt);
			fresh    = 1'b1;
			echo_cnt = '0;
		end
		echo_prev = lvl;

		// indicator
		if (wait_cnt != '0) begin
			wait_cnt = wait_cnt - WAIT_W'(1);
		end else if (dist_reg > upb_pkg::DIST_W'(far_reg)) begin
			led_reg = 1'b0;
		end else if (dist_reg > upb_pkg::DIST_W'(near_reg)) begin
			w        = blink_ticks(dist_reg);
			led_reg  = ~led_reg;
			wait_cnt = (w == '0) ? '0 : w - WAIT_W'(1);
		end else begin
			led_reg = 1'b1;
		end

		res.trigger_out  = trig;
		res.led_out      = led_reg;
		res.distance_mm  = dist_reg;
		res.distance_new = fresh;
	endtask

	// one echo transfer, then log what it must produce
	task automatic send_tick(input logic lvl);
		int                 gap;
		upb_pkg::out_item_t reading;
		gap = tx_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			echo_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		echo_ch.valid              <= 1'b1;
		echo_ch.payload.echo_level <= lvl;
		do @(posedge clk); while (!echo_ch.ready);
		advance_sensor(lvl, reading);
		pending_readings.push_back(reading);
	endtask

	// a pulse ending exactly on the far limit would hold the led for good
	task automatic send_echo_safe(input logic lvl);
		if (!lvl && echo_prev && ticks_to_mm(echo_cnt) == upb_pkg::DIST_W'(far_reg))
			lvl = 1'b1;
		send_tick(lvl);
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle_block();
		echo_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input upb_pkg::cfg_index_t idx,
			input logic [upb_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic program_limits(
		input logic [upb_pkg::PERIOD_W-1:0] period,
		input logic [upb_pkg::PULSE_W-1:0]  width,
		input logic [upb_pkg::LIMIT_W-1:0]  near,
		input logic [upb_pkg::LIMIT_W-1:0]  far,
		input logic [upb_pkg::FAST_W-1:0]   fastest
	);
		settle_block();
		put_reg(upb_pkg::CFG_TRIGGER_PERIOD, upb_pkg::CFG_DATA_W'(period));
		put_reg(upb_pkg::CFG_TRIGGER_WIDTH, upb_pkg::CFG_DATA_W'(width));
		put_reg(upb_pkg::CFG_NEAR_LIMIT, upb_pkg::CFG_DATA_W'(near));
		put_reg(upb_pkg::CFG_FAR_LIMIT, upb_pkg::CFG_DATA_W'(far));
		put_reg(upb_pkg::CFG_FASTEST_WAIT, upb_pkg::CFG_DATA_W'(fastest));
		cfg_we      <= 1'b0;
		period_reg  = period;
		width_reg   = width;
		near_reg    = near;
		far_reg     = far;
		fastest_reg = fastest;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// result sink with random stalls
	initial begin : result_sink
		int                 stall;
		upb_pkg::out_item_t got;
		upb_pkg::out_item_t want;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got = result_ch.payload;
			if (pending_readings.size() == 0) begin
				$display("%0t: result expected none actual %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_readings.pop_front();
				check_field("trigger_out", 32'(want.trigger_out), 32'(got.trigger_out));
				check_field("led_out", 32'(want.led_out), 32'(got.led_out));
				check_field("distance_mm", 32'(want.distance_mm), 32'(got.distance_mm));
				check_field("distance_new", 32'(want.distance_new),
					32'(got.distance_new));
			end
			if ($urandom_range(0, 63) == 0)
				rx_steady = ~rx_steady;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((echo_ch.valid && echo_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// reset settings, first trigger pulse and lit led at start-up
	task automatic test_startup();
		repeat (3) send_tick(1'b0);
	endtask

	// zero period, zero width, width over period, both extremes
	task automatic test_trigger_shapes();
		program_limits(20'd0, 8'd2, 16'd250, 16'd1250, 16'd5000);
		repeat (2) send_tick(1'b0);
		program_limits(20'd3, 8'd0, 16'd250, 16'd1250, 16'd5000);
		repeat (2) send_tick(1'b0);
		program_limits(20'hFFFFF, 8'hFF, 16'd250, 16'd1250, 16'd5000);
		repeat (2) send_tick(1'b0);
		program_limits(20'd1, 8'd1, 16'd250, 16'd1250, 16'd5000);
		repeat (2) send_tick(1'b0);
	endtask

	// blink band, zero wait, inverted and extreme limits
	task automatic test_distance_bands();
		// 2 ticks of echo gives 3 mm, inside the band
		program_limits(20'd1, 8'd1, 16'd2, 16'd5, 16'd0);
		send_tick(1'b1);
		send_tick(1'b1);
		repeat (3) send_tick(1'b0);
		// far below near: anything measured is beyond far
		program_limits(20'd1, 8'd1, 16'hFFFF, 16'd0, 16'd1);
		send_tick(1'b0);
		// widest band, the wait comes out as one tick
		program_limits(20'd1, 8'd1, 16'd0, 16'hFFFF, 16'd1);
		repeat (2) send_tick(1'b0);
		// empty band with distance on both limits
		program_limits(20'd1, 8'd1, 16'd3, 16'd3, 16'd1);
		send_tick(1'b0);
	endtask

	// echo pulses with random length, plus random chatter on the line
	task automatic run_pulse_train(input int n_items);
		int sent;
		int run;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 80) begin
				run = ($urandom_range(0, 15) == 0) ? $urandom_range(31, 120)
					: $urandom_range(1, 30);
				repeat (run) send_echo_safe(1'b1);
				sent += run;
				run = $urandom_range(1, 12);
				repeat (run) send_echo_safe(1'b0);
				sent += run;
			end else begin
				run = $urandom_range(1, 8);
				repeat (run) send_echo_safe(1'($urandom_range(0, 1)));
				sent += run;
			end
			if ($urandom_range(0, 15) == 0)
				tx_steady = ~tx_steady;
		end
	endtask

	task automatic test_random_traffic();
		logic [upb_pkg::PERIOD_W-1:0] period;
		logic [upb_pkg::PULSE_W-1:0]  width;
		logic [upb_pkg::LIMIT_W-1:0]  near;
		logic [upb_pkg::LIMIT_W-1:0]  far;
		logic [upb_pkg::FAST_W-1:0]   fastest;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 3) begin
				// full-range registers, band kept out of reach of the pulses
				period  = upb_pkg::PERIOD_W'($urandom_range(0, 20'hFFFFF));
				width   = upb_pkg::PULSE_W'($urandom_range(0, 255));
				near    = upb_pkg::LIMIT_W'($urandom_range(256, 65535));
				far     = upb_pkg::LIMIT_W'($urandom_range(0, 65535));
				fastest = upb_pkg::FAST_W'($urandom_range(0, 65535));
			end else begin
				// small settings so pulses land in the band and waits stay short
				period  = ($urandom_range(0, 7) == 0)
					? upb_pkg::PERIOD_W'($urandom_range(0, 3))
					: upb_pkg::PERIOD_W'($urandom_range(4, 60));
				width   = ($urandom_range(0, 7) == 0) ? 8'hFF
					: upb_pkg::PULSE_W'($urandom_range(0, 40));
				near    = upb_pkg::LIMIT_W'($urandom_range(0, 20));
				far     = ($urandom_range(0, 5) == 0)
					? upb_pkg::LIMIT_W'($urandom_range(0, near))
					: near + upb_pkg::LIMIT_W'($urandom_range(1, 40));
				fastest = upb_pkg::FAST_W'($urandom_range(0, 4));
			end
			// a distance already on the far limit would hold the led for good
			if (upb_pkg::DIST_W'(far) == dist_reg)
				far = far + upb_pkg::LIMIT_W'(1);
			program_limits(period, width, near, far, fastest);
			run_pulse_train(190);
		end
	endtask

	// distance on the far limit: one toggle, then the longest wait
	task automatic test_wait_saturation();
		do send_echo_safe(1'b0); while (echo_prev || wait_cnt != '0);
		program_limits(20'hFFFFF, 8'hFF, 16'd0, 16'd3, 16'hFFFF);
		send_tick(1'b1);
		send_tick(1'b1);
		repeat (4) send_tick(1'b0);
	endtask

	initial begin : test_sequence
		echo_ch.valid   <= 1'b0;
		echo_ch.payload <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= upb_pkg::CFG_TRIGGER_PERIOD;
		cfg_data        <= '0;
		arst_n          <= 1'b0;

		period_reg  = 20'd20000;
		width_reg   = 8'd5;
		near_reg    = 16'd250;
		far_reg     = 16'd1250;
		fastest_reg = 16'd5000;
		period_cnt  = '0;
		pulse_cnt   = '0;
		echo_cnt    = '0;
		echo_prev   = 1'b0;
		dist_reg    = '0;
		led_reg     = 1'b0;
		wait_cnt    = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_startup();
		test_trigger_shapes();
		test_distance_bands();
		test_random_traffic();
		test_wait_saturation();

		settle_block();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_readings.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
